// ===== sv/rsu_pkg.sv =====
package rsu_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int SPAN_W     = ADDR_W + 1;
	localparam int MAX_DEGREE = 7;
	localparam int DEG_W      = 3;
	localparam int MOD_W      = 16;
	localparam int WEIGHT_W   = 24;
	localparam int SCORE_W    = 32;
	localparam int DVD_W      = 2 * MOD_W + 1;
	localparam int POS_W      = MOD_W + 1;
	localparam int TS_W       = MOD_W + 2;
	localparam int CFG_IDX_W  = 2;
	localparam int INDEX_W    = 12;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_K_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd2;

	typedef struct packed {
		logic             go;
		logic [DVD_W-1:0] dividend;
		logic [MOD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
		logic [MOD_W-1:0] rem;
	} div_resp_t;

	typedef enum logic [27:0] {
		ST_IDLE   = 28'd1 << 0,
		ST_CLR    = 28'd1 << 1,
		ST_RD     = 28'd1 << 2,
		ST_BDIV   = 28'd1 << 3,
		ST_MDIV   = 28'd1 << 4,
		ST_LSTART = 28'd1 << 5,
		ST_LCW    = 28'd1 << 6,
		ST_HMUL   = 28'd1 << 7,
		ST_HCW    = 28'd1 << 8,
		ST_HRW    = 28'd1 << 9,
		ST_GCHK   = 28'd1 << 10,
		ST_GCD    = 28'd1 << 11,
		ST_GCDW   = 28'd1 << 12,
		ST_DRW    = 28'd1 << 13,
		ST_PPW    = 28'd1 << 14,
		ST_GDW    = 28'd1 << 15,
		ST_EE     = 28'd1 << 16,
		ST_EEW    = 28'd1 << 17,
		ST_EEM    = 28'd1 << 18,
		ST_EET    = 28'd1 << 19,
		ST_VMUL   = 28'd1 << 20,
		ST_VDIV   = 28'd1 << 21,
		ST_VW     = 28'd1 << 22,
		ST_OFW    = 28'd1 << 23,
		ST_HIT    = 28'd1 << 24,
		ST_HWR    = 28'd1 << 25,
		ST_NEXT   = 28'd1 << 26,
		ST_SPARE  = 28'd1 << 27
	} state_t;

endpackage

// ===== sv/rsu_div.sv =====
module rsu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rsu_pkg::div_req_t   req,
	output rsu_pkg::div_resp_t  resp
);

	localparam logic [5:0] LAST = 6'(rsu_pkg::DVD_W - 1);

	logic                      busy_q;
	logic                      done_q;
	logic [5:0]                cnt_q;
	logic [rsu_pkg::MOD_W-1:0] dvs_q;
	logic [rsu_pkg::DVD_W-1:0] quo_q;
	logic [rsu_pkg::MOD_W-1:0] rem_q;

	logic [rsu_pkg::MOD_W:0]   trial;
	logic [rsu_pkg::MOD_W:0]   diff;
	logic                      fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[rsu_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[rsu_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? diff[rsu_pkg::MOD_W-1:0] : trial[rsu_pkg::MOD_W-1:0];
		end
	end

	assign resp.done = done_q;
	assign resp.quo  = quo_q;
	assign resp.rem  = rem_q;

endmodule

// ===== sv/rsu_ram.sv =====
module rsu_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rsu_pkg::ADDR_W-1:0]  waddr,
	input  logic [rsu_pkg::SCORE_W-1:0] wdata,
	input  logic [rsu_pkg::ADDR_W-1:0]  raddr,
	output logic [rsu_pkg::SCORE_W-1:0] rdata
);

	logic [rsu_pkg::SCORE_W-1:0] mem [rsu_pkg::TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/root_sieve_table_update_top.sv =====
// channel   ports                                                  handshake
// config    cfg_we cfg_index cfg_data                              write when cfg_we
// command   command index coeff_value modulus m_residue            transfer at start & !busy
//           b_residue alpha_weight
// result    status read_value                                      valid one cycle with done
//
// load stores a coefficient, read passes state RD, clear zeroes one ram entry per cycle.
// a run walks every residue l below the modulus; each l makes passes through the shared
// bit-serial divider (2*degree+1 passes for the polynomial, more for gcd and inverse)
// plus states HIT and HWR for each table entry hit (read, then write back).
// after reset the score ram is swept to zero, all 4096 entries, with busy high.
// results are shown for one cycle with done; the receiver cannot stall them.
module root_sieve_table_update_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rsu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           command,
	input  logic [rsu_pkg::INDEX_W-1:0]          index,
	input  logic [rsu_pkg::MOD_W-1:0]            coeff_value,
	input  logic [rsu_pkg::MOD_W-1:0]            modulus,
	input  logic [rsu_pkg::MOD_W-1:0]            m_residue,
	input  logic [rsu_pkg::MOD_W-1:0]            b_residue,
	input  logic [rsu_pkg::WEIGHT_W-1:0]         alpha_weight,
	output logic                                 done,
	output logic                                 status,
	output logic signed [rsu_pkg::SCORE_W-1:0]   read_value
);

	localparam int MW = rsu_pkg::MOD_W;
	localparam int DW = rsu_pkg::DVD_W;

	rsu_pkg::state_t state_q;

	logic signed [31:0]               k_low_q;
	logic signed [31:0]               k_high_q;
	logic [rsu_pkg::DEG_W-1:0]        degree_q;
	logic [MW-1:0]                    coef_q [rsu_pkg::MAX_DEGREE+1];

	logic                             done_q;
	logic                             status_q;
	logic [rsu_pkg::SCORE_W-1:0]      read_value_q;
	logic                             emit_q;
	logic [rsu_pkg::ADDR_W-1:0]       clr_cnt_q;

	logic [MW-1:0]                    pn_q, m_q, bb_q, g_q, l_q, r_q;
	logic [rsu_pkg::WEIGHT_W-1:0]     w_q;
	logic [rsu_pkg::SPAN_W-1:0]       span_q;
	logic [rsu_pkg::DEG_W-1:0]        i_q;
	logic [2*MW-1:0]                  prod_q;
	logic [MW-1:0]                    ga_q, gb_q, d_q, rd_q, pp_q, r0_q, r1_q, eq_q, inv_q;
	logic signed [rsu_pkg::TS_W-1:0]  t0_q, t1_q;
	logic signed [MW+rsu_pkg::TS_W:0] tprod_q;
	logic                             xneg_q;
	logic [rsu_pkg::POS_W-1:0]        pos_q;

	logic                             div_go_q;
	logic [DW-1:0]                    div_dvd_q;
	logic [MW-1:0]                    div_dvs_q;
	rsu_pkg::div_req_t                div_req;
	rsu_pkg::div_resp_t               div_resp;

	logic                             accept;
	logic signed [33:0]               span_w;
	logic [rsu_pkg::DEG_W-1:0]        coef_addr;
	logic [MW-1:0]                    coef_rd;
	logic                             ram_we;
	logic [rsu_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
	logic [rsu_pkg::SCORE_W-1:0]      ram_wdata, ram_rdata;
	logic signed [32:0]               sub_w;
	logic signed [33:0]               x_w;
	logic [33:0]                      xabs_w;
	logic [MW:0]                      gsum_w;
	logic signed [rsu_pkg::TS_W-1:0]  inv_w;

	assign accept = start && !busy;
	assign busy   = state_q != rsu_pkg::ST_IDLE;
	assign span_w = {{2{k_high_q[31]}}, k_high_q} - {{2{k_low_q[31]}}, k_low_q} + 34'sd1;

	assign coef_addr = (state_q == rsu_pkg::ST_LSTART) ? degree_q : i_q - 3'd1;
	assign coef_rd   = coef_q[coef_addr];

	// residue minus k_low, then reduced modulo pp with sign fix-up
	assign x_w    = $signed({18'd0, div_resp.rem}) - {{2{k_low_q[31]}}, k_low_q};
	assign xabs_w = x_w[33] ? 34'(-x_w) : 34'(x_w);
	assign gsum_w = {1'b0, g_q} + {1'b0, pn_q} - {1'b0, bb_q};
	assign inv_w  = t0_q[rsu_pkg::TS_W-1] ? t0_q + $signed({2'b00, pp_q}) : t0_q;

	assign sub_w = $signed({ram_rdata[31], ram_rdata}) - $signed({9'd0, w_q});

	assign ram_we    = (state_q == rsu_pkg::ST_CLR) || (state_q == rsu_pkg::ST_HWR);
	assign ram_waddr = (state_q == rsu_pkg::ST_CLR) ? clr_cnt_q : pos_q[rsu_pkg::ADDR_W-1:0];
	assign ram_wdata = (state_q == rsu_pkg::ST_CLR) ? '0 :
		(sub_w < -33'sd2147483648) ? 32'h8000_0000 : sub_w[31:0];
	assign ram_raddr = (state_q == rsu_pkg::ST_IDLE) ? index : pos_q[rsu_pkg::ADDR_W-1:0];

	assign div_req.go       = div_go_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = div_dvs_q;

	rsu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	rsu_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_low_q  <= '0;
			k_high_q <= 32'sd4095;
			degree_q <= 3'd6;
		end else if (cfg_we) begin
			case (cfg_index)
				rsu_pkg::REG_K_LOW:  k_low_q  <= cfg_data;
				rsu_pkg::REG_K_HIGH: k_high_q <= cfg_data;
				rsu_pkg::REG_DEGREE: degree_q <= cfg_data[rsu_pkg::DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == rsu_pkg::CMD_LOAD && index <= 12'(rsu_pkg::MAX_DEGREE)) begin
			coef_q[index[rsu_pkg::DEG_W-1:0]] <= coeff_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rsu_pkg::ST_CLR;
			clr_cnt_q    <= '0;
			emit_q       <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			read_value_q <= '0;
			div_go_q     <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				rsu_pkg::ST_IDLE: begin
					if (accept) begin
						pn_q <= modulus;
						m_q  <= m_residue;
						w_q  <= alpha_weight;
						span_q <= span_w[rsu_pkg::SPAN_W-1:0];
						status_q     <= 1'b0;
						read_value_q <= '0;
						case (command)
							rsu_pkg::CMD_LOAD: done_q <= 1'b1;
							rsu_pkg::CMD_RUN: begin
								if (span_w > $signed(34'(rsu_pkg::TABLE_SIZE))) begin
									status_q <= 1'b1;
									done_q   <= 1'b1;
								end else if (span_w > 34'sd0 && modulus >= 16'd2) begin
									div_go_q  <= 1'b1;
									div_dvd_q <= DW'(b_residue);
									div_dvs_q <= modulus;
									state_q   <= rsu_pkg::ST_BDIV;
								end else begin
									done_q <= 1'b1;
								end
							end
							rsu_pkg::CMD_READ: state_q <= rsu_pkg::ST_RD;
							default: begin
								clr_cnt_q <= '0;
								emit_q    <= 1'b1;
								state_q   <= rsu_pkg::ST_CLR;
							end
						endcase
					end
				end
				rsu_pkg::ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= rsu_pkg::ST_IDLE;
						done_q  <= emit_q;
						emit_q  <= 1'b0;
					end
				end
				rsu_pkg::ST_RD: begin
					read_value_q <= ram_rdata;
					done_q       <= 1'b1;
					state_q      <= rsu_pkg::ST_IDLE;
				end
				rsu_pkg::ST_BDIV: begin
					if (div_resp.done) begin
						bb_q      <= div_resp.rem;
						div_go_q  <= 1'b1;
						div_dvd_q <= DW'(m_q);
						state_q   <= rsu_pkg::ST_MDIV;
					end
				end
				rsu_pkg::ST_MDIV: begin
					if (div_resp.done) begin
						g_q     <= div_resp.rem;
						l_q     <= '0;
						state_q <= rsu_pkg::ST_LSTART;
					end
				end
				rsu_pkg::ST_LSTART: begin
					i_q       <= degree_q;
					div_go_q  <= 1'b1;
					div_dvd_q <= DW'(coef_rd);
					div_dvs_q <= pn_q;
					state_q   <= rsu_pkg::ST_LCW;
				end
				rsu_pkg::ST_LCW: begin
					if (div_resp.done) begin
						r_q     <= div_resp.rem;
						state_q <= (i_q == '0) ? rsu_pkg::ST_GCHK : rsu_pkg::ST_HMUL;
					end
				end
				rsu_pkg::ST_HMUL: begin
					prod_q    <= r_q * l_q;
					div_go_q  <= 1'b1;
					div_dvd_q <= DW'(coef_rd);
					div_dvs_q <= pn_q;
					state_q   <= rsu_pkg::ST_HCW;
				end
				rsu_pkg::ST_HCW: begin
					if (div_resp.done) begin
						div_go_q  <= 1'b1;
						div_dvd_q <= {1'b0, prod_q} + DW'(div_resp.rem);
						state_q   <= rsu_pkg::ST_HRW;
					end
				end
				rsu_pkg::ST_HRW: begin
					if (div_resp.done) begin
						r_q     <= div_resp.rem;
						i_q     <= i_q - 3'd1;
						state_q <= (i_q == 3'd1) ? rsu_pkg::ST_GCHK : rsu_pkg::ST_HMUL;
					end
				end
				rsu_pkg::ST_GCHK: begin
					ga_q    <= g_q;
					gb_q    <= pn_q;
					state_q <= (g_q == '0) ? rsu_pkg::ST_NEXT : rsu_pkg::ST_GCD;
				end
				rsu_pkg::ST_GCD: begin
					div_go_q <= 1'b1;
					if (gb_q == '0) begin
						d_q       <= ga_q;
						div_dvd_q <= DW'(r_q);
						div_dvs_q <= ga_q;
						state_q   <= rsu_pkg::ST_DRW;
					end else begin
						div_dvd_q <= DW'(ga_q);
						div_dvs_q <= gb_q;
						state_q   <= rsu_pkg::ST_GCDW;
					end
				end
				rsu_pkg::ST_GCDW: begin
					if (div_resp.done) begin
						ga_q    <= gb_q;
						gb_q    <= div_resp.rem;
						state_q <= rsu_pkg::ST_GCD;
					end
				end
				rsu_pkg::ST_DRW: begin
					if (div_resp.done) begin
						if (div_resp.rem != '0) begin
							state_q <= rsu_pkg::ST_NEXT;
						end else begin
							rd_q      <= div_resp.quo[MW-1:0];
							div_go_q  <= 1'b1;
							div_dvd_q <= DW'(pn_q);
							div_dvs_q <= d_q;
							state_q   <= rsu_pkg::ST_PPW;
						end
					end
				end
				rsu_pkg::ST_PPW: begin
					if (div_resp.done) begin
						pp_q      <= div_resp.quo[MW-1:0];
						div_go_q  <= 1'b1;
						div_dvd_q <= DW'(g_q);
						state_q   <= rsu_pkg::ST_GDW;
					end
				end
				rsu_pkg::ST_GDW: begin
					if (div_resp.done) begin
						r1_q    <= div_resp.quo[MW-1:0];
						r0_q    <= pp_q;
						t0_q    <= '0;
						t1_q    <= 18'sd1;
						state_q <= rsu_pkg::ST_EE;
					end
				end
				// extended euclid for the inverse of g/d modulo pp
				rsu_pkg::ST_EE: begin
					if (r1_q == '0) begin
						inv_q   <= inv_w[MW-1:0];
						state_q <= rsu_pkg::ST_VMUL;
					end else begin
						div_go_q  <= 1'b1;
						div_dvd_q <= DW'(r0_q);
						div_dvs_q <= r1_q;
						state_q   <= rsu_pkg::ST_EEW;
					end
				end
				rsu_pkg::ST_EEW: begin
					if (div_resp.done) begin
						eq_q    <= div_resp.quo[MW-1:0];
						r0_q    <= r1_q;
						r1_q    <= div_resp.rem;
						state_q <= rsu_pkg::ST_EEM;
					end
				end
				rsu_pkg::ST_EEM: begin
					tprod_q <= $signed({1'b0, eq_q}) * t1_q;
					state_q <= rsu_pkg::ST_EET;
				end
				rsu_pkg::ST_EET: begin
					t0_q    <= t1_q;
					t1_q    <= t0_q - tprod_q[rsu_pkg::TS_W-1:0];
					state_q <= rsu_pkg::ST_EE;
				end
				rsu_pkg::ST_VMUL: begin
					prod_q  <= rd_q * inv_q;
					state_q <= rsu_pkg::ST_VDIV;
				end
				rsu_pkg::ST_VDIV: begin
					div_go_q  <= 1'b1;
					div_dvd_q <= {1'b0, prod_q};
					div_dvs_q <= pp_q;
					state_q   <= rsu_pkg::ST_VW;
				end
				rsu_pkg::ST_VW: begin
					if (div_resp.done) begin
						xneg_q    <= x_w[33];
						div_go_q  <= 1'b1;
						div_dvd_q <= xabs_w[DW-1:0];
						state_q   <= rsu_pkg::ST_OFW;
					end
				end
				rsu_pkg::ST_OFW: begin
					if (div_resp.done) begin
						pos_q <= (xneg_q && div_resp.rem != '0) ?
							{1'b0, pp_q - div_resp.rem} : {1'b0, div_resp.rem};
						state_q <= rsu_pkg::ST_HIT;
					end
				end
				rsu_pkg::ST_HIT: begin
					state_q <= (pos_q < rsu_pkg::POS_W'(span_q)) ?
						rsu_pkg::ST_HWR : rsu_pkg::ST_NEXT;
				end
				rsu_pkg::ST_HWR: begin
					pos_q   <= pos_q + {1'b0, pp_q};
					state_q <= rsu_pkg::ST_HIT;
				end
				rsu_pkg::ST_NEXT: begin
					g_q <= (gsum_w >= {1'b0, pn_q}) ? gsum_w[MW-1:0] - pn_q : gsum_w[MW-1:0];
					if (l_q == pn_q - 16'd1) begin
						done_q  <= 1'b1;
						state_q <= rsu_pkg::ST_IDLE;
					end else begin
						l_q     <= l_q + 16'd1;
						state_q <= rsu_pkg::ST_LSTART;
					end
				end
				default: state_q <= rsu_pkg::ST_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == rsu_pkg::ST_IDLE)
		else $error("result strobe outside idle");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == rsu_pkg::ST_CLR || state_q == rsu_pkg::ST_HWR))
		else $error("score ram write outside clear or update");

	a_hwr_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rsu_pkg::ST_HWR |-> $past(state_q) == rsu_pkg::ST_HIT)
		else $error("write back without preceding read");

	a_hwr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rsu_pkg::ST_HWR |-> pos_q < rsu_pkg::POS_W'(span_q))
		else $error("table update beyond range");

endmodule
